[rtl/ambd_pkg.sv]
package ambd_pkg;

  // Sample width
  localparam int unsigned SAMPLE_BITS = 16;

  // Fixed field widths
  localparam int unsigned HP_W    = 17;
  localparam int unsigned SQ_W    = 36;
  localparam int unsigned DECAY_W = 9;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned RUN_W   = 6;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned AXES    = 3;
  localparam int unsigned AXIS_W  = 2;

  // Register reset values and the decay limit
  localparam logic [DECAY_W-1:0] DECAY_RST = 9'd205;
  localparam logic [THR_W-1:0]   THR_RST   = 16'd6144;
  localparam logic [RUN_W-1:0]   RUN_RST   = 6'd5;
  localparam logic [DECAY_W-1:0] DECAY_MAX = 9'd256;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_DECAY = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_THR   = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_RUN   = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_AVG,
    ST_DEC,
    ST_HP,
    ST_DIFF,
    ST_SQ,
    ST_FIN
  } state_e;

  // Operand selection for the shared multiplier
  typedef enum logic [2:0] {
    MS_NONE,
    MS_THR,
    MS_RECIP,
    MS_DECAY,
    MS_SQUARE
  } mul_sel_e;

  // Controls from the sequencer to the datapath
  typedef struct packed {
    logic              ready;
    logic              start;
    logic [AXIS_W-1:0] axis;
    logic              acc_en;
    logic              ring_wr;
    logic              thr_wr;
    logic              avg_wr;
    logic              hp_wr;
    logic              diff_wr;
    logic              load;
    mul_sel_e          mul_sel;
  } ctrl_t;

endpackage

[rtl/ambd_mul.sv]
module ambd_mul #(
  parameter int unsigned W = 22
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  logic signed [2*W-1:0] p_q;

  // Registered signed product, held while idle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

[rtl/ambd_ctrl.sv]
module ambd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_free_i,
  output ambd_pkg::ctrl_t ctrl_o
);

  ambd_pkg::state_e              state_q, state_d;
  logic [ambd_pkg::AXIS_W-1:0]   axis_q, axis_d;
  logic                          last_axis;

  assign last_axis = (axis_q == ambd_pkg::AXIS_W'(ambd_pkg::AXES - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    unique case (state_q)
      ambd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ambd_pkg::ST_SUM;
          axis_d  = '0;
        end
      end
      ambd_pkg::ST_SUM:  state_d = ambd_pkg::ST_AVG;
      ambd_pkg::ST_AVG:  state_d = ambd_pkg::ST_DEC;
      ambd_pkg::ST_DEC:  state_d = ambd_pkg::ST_HP;
      ambd_pkg::ST_HP:   state_d = ambd_pkg::ST_DIFF;
      ambd_pkg::ST_DIFF: state_d = ambd_pkg::ST_SQ;
      ambd_pkg::ST_SQ: begin
        if (last_axis) begin
          state_d = ambd_pkg::ST_FIN;
        end else begin
          state_d = ambd_pkg::ST_SUM;
          axis_d  = axis_q + 1'b1;
        end
      end
      ambd_pkg::ST_FIN: begin
        if (out_free_i) begin
          state_d = ambd_pkg::ST_IDLE;
        end
      end
      default: state_d = ambd_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl_o         = '0;
    ctrl_o.axis    = axis_q;
    ctrl_o.mul_sel = ambd_pkg::MS_NONE;
    unique case (state_q)
      ambd_pkg::ST_IDLE: begin
        ctrl_o.ready = 1'b1;
        ctrl_o.start = in_valid_i;
      end
      ambd_pkg::ST_SUM: begin
        ctrl_o.ring_wr = 1'b1;
        ctrl_o.acc_en  = (axis_q != '0);
        ctrl_o.mul_sel = ambd_pkg::MS_THR;
      end
      ambd_pkg::ST_AVG: begin
        ctrl_o.thr_wr  = 1'b1;
        ctrl_o.mul_sel = ambd_pkg::MS_RECIP;
      end
      ambd_pkg::ST_DEC: begin
        ctrl_o.avg_wr  = 1'b1;
        ctrl_o.mul_sel = ambd_pkg::MS_DECAY;
      end
      ambd_pkg::ST_HP:   ctrl_o.hp_wr = 1'b1;
      ambd_pkg::ST_DIFF: ctrl_o.diff_wr = 1'b1;
      ambd_pkg::ST_SQ:   ctrl_o.mul_sel = ambd_pkg::MS_SQUARE;
      ambd_pkg::ST_FIN: begin
        ctrl_o.load = out_free_i;
      end
      default: ctrl_o.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ambd_pkg::ST_IDLE;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

endmodule

[rtl/accel_motion_burst_detector.sv]
// Channel   Dir  Handshake                     Payload (lowest bit first)
// s_axis    in   s_axis_tvalid/s_axis_tready   sample_x, sample_y, sample_z
// m_axis    out  m_axis_tvalid/m_axis_tready   hp_x, hp_y, hp_z, change_sq,
//                                              over_threshold, run_count, detected
// cfg       in   cfg_we_i (no wait)            decay_q8, threshold_lsb, run_length
//
// A request is processed fully before the next one is accepted: six sequencer
// steps per axis (sum, average, decay, high-pass, difference, square) plus a final
// compare step, the multiplying steps sharing one registered signed multiplier.
// s_axis_tready is high only in idle. Reset clears the sample ring, sums, history,
// run count and output valid, and sets config reset values. A held result does not
// block the next accept; only the final step waits for a free output register.
module accel_motion_burst_detector #(
  parameter int unsigned WINDOW      = 5
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // sample_x, sample_y, sample_z
  input  logic [((3*ambd_pkg::SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,

  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // hp_x, hp_y, hp_z, change_sq, over_threshold, run_count, detected, zero pad
  output logic [95:0]                            m_axis_tdata,

  input  logic                                   cfg_we_i,
  input  logic [ambd_pkg::CFG_A_W-1:0]           cfg_addr_i,
  input  logic [ambd_pkg::THR_W-1:0]             cfg_wdata_i
);

  localparam int unsigned SB    = ambd_pkg::SAMPLE_BITS;
  localparam int unsigned L     = $clog2(WINDOW);
  localparam int unsigned N     = SB + L + 1;               // sum / biased sum width
  localparam int unsigned HW    = SB + 1;                   // high-pass width
  localparam int unsigned DW    = SB + 2;                   // high-pass change width
  localparam int unsigned SQI_W = 2 * SB + 4;               // change_sq internal width
  localparam int unsigned MW    = (N + 2 > 17) ? N + 2 : 17;
  localparam int unsigned PW    = 2 * MW;
  localparam int unsigned THQ_W = 2 * ambd_pkg::THR_W;
  localparam int unsigned CMP_W = (SQI_W > THQ_W) ? SQI_W : THQ_W;
  localparam int unsigned PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned OUT_W = 3 * ambd_pkg::HP_W + ambd_pkg::SQ_W + ambd_pkg::RUN_W + 2;

  // floor(u / WINDOW) = (u * RECIP) >> (N + L) for every u below 2^N
  localparam longint unsigned RECIP = ((64'd1 << (N + L)) + WINDOW - 1) / WINDOW;
  localparam logic signed [MW-1:0] RECIP_M = MW'(RECIP);
  // Bias that makes the running sum non-negative
  localparam logic [N-1:0] BIAS = N'(WINDOW * (2 ** (SB - 1)));

  ambd_pkg::ctrl_t ctrl;

  // Configuration registers
  logic [ambd_pkg::DECAY_W-1:0] decay_q;
  logic [ambd_pkg::THR_W-1:0]   thr_q;
  logic [ambd_pkg::RUN_W-1:0]   run_len_q;

  // Item state
  logic signed [SB-1:0] ring_q [WINDOW][ambd_pkg::AXES];
  logic [PTR_W-1:0]     ptr_q;
  logic signed [N-1:0]  sum_q [ambd_pkg::AXES];
  logic signed [SB-1:0] prev_avg_q [ambd_pkg::AXES];
  logic signed [HW-1:0] prev_hp_q [ambd_pkg::AXES];
  logic [ambd_pkg::RUN_W-1:0] cnt_q;

  // Working registers
  logic signed [SB-1:0] smp_q [ambd_pkg::AXES];
  logic signed [SB-1:0] avg_q;
  logic signed [HW-1:0] hp_q [ambd_pkg::AXES];
  logic signed [DW-1:0] diff_q;
  logic [SQI_W-1:0]     sq_q;
  logic [THQ_W-1:0]     thr_sq_q;

  // Output register
  logic              m_valid_q;
  logic [OUT_W-1:0]  out_q;

  logic                         out_free;
  logic signed [MW-1:0]         mul_a, mul_b;
  logic signed [PW-1:0]         prod;
  logic                         mul_en;
  logic [N-1:0]                 u_w;
  logic [SB-1:0]                quot_w;
  logic signed [SB-1:0]         dec_w;
  logic signed [N-1:0]          sum_w;
  logic [ambd_pkg::DECAY_W-1:0] decay_c;
  logic [SQI_W-1:0]             sq_tot;
  logic                         over;
  logic [ambd_pkg::RUN_W-1:0]   need, cnt_inc, cnt_d;
  logic                         det;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = ctrl.ready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = 96'(out_q);

  ambd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  // Shared multiplier operands
  assign decay_c = (decay_q > ambd_pkg::DECAY_MAX) ? ambd_pkg::DECAY_MAX : decay_q;
  assign u_w     = $unsigned(sum_q[ctrl.axis]) + BIAS;
  assign mul_en  = (ctrl.mul_sel != ambd_pkg::MS_NONE);

  always_comb begin
    case (ctrl.mul_sel)
      ambd_pkg::MS_THR: begin
        mul_a = MW'({1'b0, thr_q});
        mul_b = MW'({1'b0, thr_q});
      end
      ambd_pkg::MS_RECIP: begin
        mul_a = MW'({1'b0, u_w});
        mul_b = RECIP_M;
      end
      ambd_pkg::MS_DECAY: begin
        mul_a = MW'({1'b0, decay_c});
        mul_b = MW'(prev_avg_q[ctrl.axis]);
      end
      ambd_pkg::MS_SQUARE: begin
        mul_a = MW'(diff_q);
        mul_b = MW'(diff_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ambd_mul #(.W(MW)) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Datapath terms
  assign sum_w  = sum_q[ctrl.axis] + N'(smp_q[ctrl.axis]) - N'(ring_q[ptr_q][ctrl.axis]);
  assign quot_w = prod[N+L +: SB];
  assign dec_w  = prod[8 +: SB];
  assign sq_tot = sq_q + prod[SQI_W-1:0];
  assign over   = CMP_W'(sq_tot) > CMP_W'(thr_sq_q);

  // Run counter
  assign need    = (run_len_q == '0) ? ambd_pkg::RUN_W'(1) : run_len_q;
  assign cnt_inc = cnt_q + 1'b1;
  always_comb begin
    det   = 1'b0;
    cnt_d = '0;
    if (over) begin
      if (cnt_inc >= need) begin
        det = 1'b1;
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q   <= ambd_pkg::DECAY_RST;
      thr_q     <= ambd_pkg::THR_RST;
      run_len_q <= ambd_pkg::RUN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ambd_pkg::CFG_DECAY: decay_q   <= cfg_wdata_i[ambd_pkg::DECAY_W-1:0];
        ambd_pkg::CFG_THR:   thr_q     <= cfg_wdata_i;
        ambd_pkg::CFG_RUN:   run_len_q <= cfg_wdata_i[ambd_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // Filter state: ring, sums, history, run count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < WINDOW; w++) begin
        for (int a = 0; a < ambd_pkg::AXES; a++) begin
          ring_q[w][a] <= '0;
        end
      end
      for (int a = 0; a < ambd_pkg::AXES; a++) begin
        sum_q[a]      <= '0;
        prev_avg_q[a] <= '0;
        prev_hp_q[a]  <= '0;
      end
      ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (ctrl.ring_wr) begin
        sum_q[ctrl.axis]         <= sum_w;
        ring_q[ptr_q][ctrl.axis] <= smp_q[ctrl.axis];
      end
      if (ctrl.hp_wr) begin
        prev_avg_q[ctrl.axis] <= avg_q;
      end
      if (ctrl.diff_wr) begin
        prev_hp_q[ctrl.axis] <= hp_q[ctrl.axis];
      end
      if (ctrl.load) begin
        cnt_q <= cnt_d;
        ptr_q <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
      end
    end
  end

  // Per-request working registers
  always_ff @(posedge clk_i) begin
    if (ctrl.start) begin
      smp_q[0] <= s_axis_tdata[0 +: SB];
      smp_q[1] <= s_axis_tdata[SB +: SB];
      smp_q[2] <= s_axis_tdata[2*SB +: SB];
      sq_q     <= '0;
    end
    if (ctrl.acc_en) begin
      sq_q <= sq_tot;
    end
    if (ctrl.thr_wr) begin
      thr_sq_q <= prod[THQ_W-1:0];
    end
    // average = floor(u / WINDOW) - 2^(SB-1): flip the top bit
    if (ctrl.avg_wr) begin
      avg_q <= {~quot_w[SB-1], quot_w[SB-2:0]};
    end
    if (ctrl.hp_wr) begin
      hp_q[ctrl.axis] <= HW'(avg_q) - HW'(dec_w);
    end
    if (ctrl.diff_wr) begin
      diff_q <= DW'(hp_q[ctrl.axis]) - DW'(prev_hp_q[ctrl.axis]);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctrl.load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      out_q <= {det, cnt_d, over, ambd_pkg::SQ_W'(sq_tot),
                ambd_pkg::HP_W'(hp_q[2]), ambd_pkg::HP_W'(hp_q[1]),
                ambd_pkg::HP_W'(hp_q[0])};
    end
  end

endmodule

[dv/accel_motion_burst_detector_test.sv]
module accel_motion_burst_detector_test;

  localparam int unsigned WIN             = 5;
  localparam int unsigned LATENCY         = 20;
  localparam int unsigned PHASES          = 12;
  localparam int unsigned ITEMS_PER_PHASE = 156;

  // Request payload, x in the lowest bits
  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } accel_sample_t;

  // Result payload, hp_x in the lowest bits
  typedef struct packed {
    logic                          detected;
    logic [ambd_pkg::RUN_W-1:0]    run_count;
    logic                          over_threshold;
    logic [ambd_pkg::SQ_W-1:0]     change_sq;
    logic [ambd_pkg::HP_W-1:0]     hp_z;
    logic [ambd_pkg::HP_W-1:0]     hp_y;
    logic [ambd_pkg::HP_W-1:0]     hp_x;
  } motion_result_t;

  // Filter/detector predictor plus the queue of predicted results
  class motion_checker;
    longint                          window [WIN][3];
    int unsigned                     wr_slot;
    longint                          axis_total [3];
    longint                          last_mean [3];
    longint                          last_hp [3];
    int unsigned                     streak;
    logic [ambd_pkg::DECAY_W-1:0]    decay_q8      = ambd_pkg::DECAY_RST;
    logic [ambd_pkg::THR_W-1:0]      threshold_lsb = ambd_pkg::THR_RST;
    logic [ambd_pkg::RUN_W-1:0]      run_length    = ambd_pkg::RUN_RST;
    motion_result_t                  predicted_hp [$];
    int unsigned                     errors;

    function void write_reg(logic [ambd_pkg::CFG_A_W-1:0] addr,
                            logic [ambd_pkg::THR_W-1:0] value);
      case (addr)
        ambd_pkg::CFG_DECAY: decay_q8 = value[ambd_pkg::DECAY_W-1:0];
        ambd_pkg::CFG_THR:   threshold_lsb = value;
        ambd_pkg::CFG_RUN:   run_length = value[ambd_pkg::RUN_W-1:0];
        default: ;
      endcase
    endfunction

    // division rounded toward minus infinity
    function longint floor_div(longint num, longint den);
      if (num >= 0) return num / den;
      return -((-num + den - 1) / den);
    endfunction

    function void note_sample(accel_sample_t s);
      longint                      smp [3];
      longint                      mean, shrink, hp, d, eff_decay;
      longint unsigned             sq, thr_sq;
      int unsigned                 need;
      motion_result_t              r;
      logic [ambd_pkg::HP_W-1:0]   hp_bits [3];
      smp[0] = longint'(s.x);
      smp[1] = longint'(s.y);
      smp[2] = longint'(s.z);
      eff_decay = longint'((decay_q8 > ambd_pkg::DECAY_MAX) ? ambd_pkg::DECAY_MAX : decay_q8);
      sq = 0;
      for (int a = 0; a < 3; a++) begin
        axis_total[a] += smp[a] - window[wr_slot][a];
        window[wr_slot][a] = smp[a];
        mean = floor_div(axis_total[a], longint'(WIN));
        shrink = floor_div(eff_decay * last_mean[a], 256);
        hp = mean - shrink;
        last_mean[a] = mean;
        d = hp - last_hp[a];
        if (d < 0) d = -d;
        sq += 64'(d * d);
        last_hp[a] = hp;
        hp_bits[a] = hp[ambd_pkg::HP_W-1:0];
      end
      wr_slot = (wr_slot == WIN - 1) ? 0 : wr_slot + 1;

      // threshold compare and run counting; run length 0 behaves as 1
      thr_sq = 64'(threshold_lsb);
      thr_sq = thr_sq * thr_sq;
      r.over_threshold = (sq > thr_sq);
      need = (run_length == 0) ? 1 : 32'(run_length);
      r.detected = 1'b0;
      if (r.over_threshold) begin
        streak = (streak + 1) & 32'h3F;
        if (streak >= need) begin
          r.detected = 1'b1;
          streak = 0;
        end
      end else begin
        streak = 0;
      end
      r.run_count = streak[ambd_pkg::RUN_W-1:0];
      r.change_sq = sq[ambd_pkg::SQ_W-1:0];
      r.hp_x = hp_bits[0];
      r.hp_y = hp_bits[1];
      r.hp_z = hp_bits[2];
      predicted_hp.push_back(r);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(motion_result_t got);
      motion_result_t want;
      if (predicted_hp.size() == 0) begin
        $error("result with no request pending: 0x%0h", got);
        errors++;
        return;
      end
      want = predicted_hp.pop_front();
      compare_field("hp_x", 64'(want.hp_x), 64'(got.hp_x));
      compare_field("hp_y", 64'(want.hp_y), 64'(got.hp_y));
      compare_field("hp_z", 64'(want.hp_z), 64'(got.hp_z));
      compare_field("change_sq", 64'(want.change_sq), 64'(got.change_sq));
      compare_field("over_threshold", 64'(want.over_threshold), 64'(got.over_threshold));
      compare_field("run_count", 64'(want.run_count), 64'(got.run_count));
      compare_field("detected", 64'(want.detected), 64'(got.detected));
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // sample_x, sample_y, sample_z
  logic [47:0]                     s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // hp_x, hp_y, hp_z, change_sq, over_threshold, run_count, detected, zero pad
  logic [95:0]                     m_axis_tdata;
  logic                            cfg_we_i = 1'b0;
  logic [ambd_pkg::CFG_A_W-1:0]    cfg_addr_i = ambd_pkg::CFG_DECAY;
  logic [ambd_pkg::THR_W-1:0]      cfg_wdata_i = '0;

  motion_checker       sb = new;
  int unsigned         send_idle_pct = 13;
  int unsigned         recv_idle_pct = 87;

  // stimulus shaping state
  int unsigned         swing_left;
  int unsigned         hold_left;
  int                  amp;
  bit                  swing_phase;
  accel_sample_t       base;

  accel_motion_burst_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver backpressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata[94:0]);
  end

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic accel_sample_t mk(int x, int y, int z);
    accel_sample_t s;
    s.x = clamp16(x);
    s.y = clamp16(y);
    s.z = clamp16(z);
    return s;
  endfunction

  // Mostly swing bursts (alternating large values) and quiet holds,
  // plus some fully random noise.
  function automatic accel_sample_t next_sample();
    accel_sample_t s;
    logic [63:0]   raw;
    int            sgn;
    raw = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 15) return raw[47:0];
    if (swing_left == 0 && hold_left == 0) begin
      if ($urandom_range(0, 1) != 0) begin
        swing_left = $urandom_range(1, 70);
        amp = int'($urandom_range(256, 32767));
      end else begin
        hold_left = $urandom_range(1, 30);
        base = raw[47:0];
      end
    end
    if (swing_left != 0) begin
      swing_left--;
      swing_phase = !swing_phase;
      sgn = swing_phase ? 1 : -1;
      s.x = clamp16(sgn * amp + int'($urandom_range(0, 63)) - 32);
      s.y = clamp16(-sgn * amp + int'($urandom_range(0, 63)) - 32);
      s.z = clamp16(sgn * (amp / 2) + int'($urandom_range(0, 63)) - 32);
    end else begin
      hold_left--;
      s.x = clamp16(int'(base.x) + int'($urandom_range(0, 31)) - 16);
      s.y = clamp16(int'(base.y) + int'($urandom_range(0, 31)) - 16);
      s.z = clamp16(int'(base.z) + int'($urandom_range(0, 31)) - 16);
    end
    return s;
  endfunction

  task automatic send_sample(accel_sample_t s);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = s;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(s);
  endtask

  // hold off requests until every predicted result has come back
  task automatic drain(bit settle);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.predicted_hp.size() != 0) @(posedge clk_i);
    if (settle) repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [ambd_pkg::CFG_A_W-1:0] addr,
                         logic [ambd_pkg::THR_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_addr_i = addr;
    cfg_wdata_i = value;
    sb.write_reg(addr, value);
  endtask

  task automatic configure(logic [ambd_pkg::DECAY_W-1:0] decay,
                           logic [ambd_pkg::THR_W-1:0] thr,
                           logic [ambd_pkg::RUN_W-1:0] run);
    put_reg(ambd_pkg::CFG_DECAY, ambd_pkg::THR_W'(decay));
    put_reg(ambd_pkg::CFG_THR, thr);
    put_reg(ambd_pkg::CFG_RUN, ambd_pkg::THR_W'(run));
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: start-up from zero history, full-scale extremes, a detection run
    send_sample(mk(0, 0, 0));
    send_sample(mk(32767, 32767, 32767));
    send_sample(mk(-32768, -32768, -32768));
    send_sample(mk(32767, -32768, 0));
    send_sample(mk(-1, 1, -1));
    for (int i = 0; i < 10; i++) begin
      if (i[0]) send_sample(mk(-32768, 32767, -32768));
      else send_sample(mk(32767, -32768, 32767));
    end
    for (int i = 0; i < 4; i++) send_sample(mk(100, 100, 100));
    send_sample(mk(-32768, 32767, 1));

    // random phases over register settings and idle modes
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 4) begin
        send_idle_pct = 13;
        recv_idle_pct = 87;
      end else if (phase < 8) begin
        send_idle_pct = 87;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain(1'b1);
      case (phase)
        0: configure(9'd0, 16'd0, 6'd63);
        1: configure(ambd_pkg::DECAY_MAX, 16'hFFFF, 6'd1);
        2: configure(9'h1FF, 16'd2000, 6'd0);
        3: configure(ambd_pkg::DECAY_RST, ambd_pkg::THR_RST, ambd_pkg::RUN_RST);
        4: configure(9'd300, 16'd1, 6'd2);
        5: configure(9'd128, 16'd12000, 6'd3);
        default: configure(ambd_pkg::DECAY_W'($urandom_range(0, 511)),
                           ambd_pkg::THR_W'($urandom_range(0, 10000)),
                           ambd_pkg::RUN_W'($urandom_range(0, 12)));
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == ITEMS_PER_PHASE / 2) drain(1'b0);
        send_sample(next_sample());
      end
    end

    drain(1'b0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (sb.errors == 0 && sb.predicted_hp.size() == 0) begin
      $display("[accel_motion_burst_detector] OK");
    end else begin
      $display("[accel_motion_burst_detector] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("[accel_motion_burst_detector] ERROR");
    $finish;
  end

endmodule
